### hw/rtl/apf_pkg.sv
package apf_pkg;
  localparam int MaxV = 32;
  localparam int VW = 5;
  localparam int CW = 6;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_ANALYZE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  localparam logic [CW-1:0] VCOUNT_RESET = 6'd32;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_ROOT,
    OP_SCAN,
    OP_POP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } apf_cmd_t;

  typedef struct packed {
    logic roots_done;
    logic scan_done;
    logic stack_empty;
  } apf_stat_t;
endpackage

### hw/rtl/apf_ctrl.sv
module apf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  apf_pkg::apf_stat_t stat,
  output apf_pkg::apf_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import apf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROOT, S_SCAN, S_POP, S_DONE} state_t;
  state_t state_r, state_nxt;
  logic done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    done_nxt = 1'b0;
    cmd.op = OP_IDLE;
    case (state_r)
      S_IDLE: if (go) state_nxt = S_INIT;
      S_INIT: begin
        cmd.op = OP_INIT;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (stat.roots_done) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) state_nxt = S_POP;
      end
      S_POP: begin
        cmd.op = OP_POP;
        if (stat.stack_empty) state_nxt = S_ROOT;
        else state_nxt = S_SCAN;
      end
      S_DONE: begin
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
endmodule

### hw/rtl/apf_dp.sv
module apf_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  apf_pkg::apf_cmd_t        cmd,
  input  logic                     edge_we,
  input  logic                     clr,
  input  logic [apf_pkg::VW-1:0]   node_a,
  input  logic [apf_pkg::VW-1:0]   node_b,
  input  logic [apf_pkg::CW-1:0]   vcount,
  output apf_pkg::apf_stat_t       stat,
  output logic [apf_pkg::MaxV-1:0] cut_mask
);
  import apf_pkg::*;

  logic [MaxV-1:0] adj_r [MaxV];
  logic [MaxV-1:0] vis_r, cut_r, live;
  logic [CW-1:0]   disc_r [MaxV];
  logic [CW-1:0]   low_r [MaxV];
  logic [VW-1:0]   par_r [MaxV];
  logic [VW-1:0]   stk_v_r [MaxV];
  logic [CW-1:0]   stk_p_r [MaxV];
  logic [CW-1:0]   dcnt_r, rch_r, pos_r, depth_r, root_r;
  logic [CW-1:0]   n;
  logic [VW-1:0]   u, w, pp;
  logic            bit_set, in_rng;

  assign n = (vcount > CW'(MaxV)) ? CW'(MaxV) : vcount;
  always_comb begin
    for (int i = 0; i < MaxV; i++) live[i] = (CW'(i) < n);
  end
  assign u = stk_v_r[depth_r[VW-1:0] - VW'(1)];
  assign w = pos_r[VW-1:0];
  assign pp = par_r[u];
  assign in_rng = pos_r < n;
  assign bit_set = in_rng && adj_r[u][w] && live[w];

  assign stat.roots_done = root_r >= n;
  assign stat.scan_done = !in_rng;
  assign stat.stack_empty = (depth_r == CW'(1)) || (depth_r == '0);
  assign cut_mask = cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxV; i++) adj_r[i] <= '0;
    end else if (clr) begin
      for (int i = 0; i < MaxV; i++) adj_r[i] <= '0;
    end else if (edge_we) begin
      adj_r[node_a][node_b] <= 1'b1;
      adj_r[node_b][node_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        vis_r <= '0;
        cut_r <= '0;
        dcnt_r <= '0;
        root_r <= '0;
        depth_r <= '0;
      end
      OP_ROOT: begin
        if (root_r < n) begin
          if (vis_r[root_r[VW-1:0]]) begin
            depth_r <= '0;
            pos_r <= n;
          end else begin
            vis_r[root_r[VW-1:0]] <= 1'b1;
            disc_r[root_r[VW-1:0]] <= dcnt_r + CW'(1);
            low_r[root_r[VW-1:0]] <= dcnt_r + CW'(1);
            par_r[root_r[VW-1:0]] <= root_r[VW-1:0];
            dcnt_r <= dcnt_r + CW'(1);
            stk_v_r[0] <= root_r[VW-1:0];
            depth_r <= CW'(1);
            pos_r <= '0;
            rch_r <= '0;
          end
        end
      end
      OP_SCAN: begin
        if (depth_r == '0) begin
          pos_r <= n;
        end else if (in_rng) begin
          pos_r <= pos_r + CW'(1);
          if (bit_set) begin
            if (!vis_r[w]) begin
              if (depth_r == CW'(1)) rch_r <= rch_r + CW'(1);
              stk_p_r[depth_r[VW-1:0] - VW'(1)] <= pos_r + CW'(1);
              vis_r[w] <= 1'b1;
              disc_r[w] <= dcnt_r + CW'(1);
              low_r[w] <= dcnt_r + CW'(1);
              par_r[w] <= u;
              dcnt_r <= dcnt_r + CW'(1);
              stk_v_r[depth_r[VW-1:0]] <= w;
              depth_r <= depth_r + CW'(1);
              pos_r <= '0;
            end else if (w != pp && disc_r[w] < low_r[u]) begin
              low_r[u] <= disc_r[w];
            end
          end
        end
      end
      OP_POP: begin
        if (depth_r > CW'(1)) begin
          if (low_r[u] < low_r[pp]) low_r[pp] <= low_r[u];
          if (depth_r > CW'(2) && low_r[u] >= disc_r[pp]) cut_r[pp] <= 1'b1;
          depth_r <= depth_r - CW'(1);
          pos_r <= stk_p_r[depth_r[VW-1:0] - VW'(2)];
        end else begin
          if (depth_r == CW'(1) && rch_r >= CW'(2)) cut_r[root_r[VW-1:0]] <= 1'b1;
          depth_r <= '0;
          root_r <= root_r + CW'(1);
        end
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/articulation_point_finder.sv
// channel | ports                          | handshake
// in      | in_func, in_node_a, in_node_b  | start & !busy
// out     | out_cut_mask                   | out_valid, one cycle
// cfg     | psel..prdata                   | APB write, pready high
// Add and clear finish without raising busy. Analyze walks the adjacency rows one
// neighbor bit per cycle while in the scan state, with root and pop steps
// between scans; busy drops with out_valid.
// Reset is synchronous, active low; it empties the matrix, count goes to 32.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module articulation_point_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_node_a,
  input  logic [4:0]  in_node_b,
  output logic        out_valid,
  output logic [31:0] out_cut_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apf_pkg::*;

  logic [CW-1:0] vcount_r;
  logic [CW-1:0] n;
  logic acc, go, edge_we, clr, ctrl_busy;
  apf_cmd_t cmd;
  apf_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {26'd0, vcount_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= VCOUNT_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) vcount_r <= pwdata[CW-1:0];
  end

  assign n = (vcount_r > CW'(MaxV)) ? CW'(MaxV) : vcount_r;
  assign acc = start && !busy;
  assign go = acc && in_func == FUNC_ANALYZE;
  assign clr = acc && in_func == FUNC_CLEAR;
  assign edge_we = acc && in_func == FUNC_ADD &&
                   ({1'b0, in_node_a} < n) && ({1'b0, in_node_b} < n);
  assign busy = ctrl_busy;

  apf_ctrl u_ctrl (.clk, .rst_n, .go, .stat, .cmd, .busy(ctrl_busy), .done(out_valid));
  apf_dp u_dp (.clk, .rst_n, .cmd, .edge_we, .clr, .node_a(in_node_a),
               .node_b(in_node_b), .vcount(vcount_r), .stat, .cut_mask(out_cut_mask));
endmodule

### hw/rtl/apf_checker.sv
module apf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic [1:0] in_func,
  input logic out_valid
);
  import apf_pkg::*;

  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_ANALYZE |=> busy) else $error("analyze not started");
  a_add_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_ADD |=> !busy) else $error("add left busy");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
endmodule

bind articulation_point_finder apf_checker u_chk (.clk, .rst_n, .start, .busy,
  .in_func, .out_valid);

### tb/sv/articulation_point_finder_tb.sv
`timescale 1ns / 1ps
module articulation_point_finder_tb;
  import apf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [4:0]  in_node_a;
  logic [4:0]  in_node_b;
  logic        out_valid;
  logic [31:0] out_cut_mask;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  articulation_point_finder u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .out_valid(out_valid), .out_cut_mask(out_cut_mask),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int LimitCycles = 3000000;
  localparam int TailCycles = 1200;

  logic [31:0] graph_rows[MaxV];
  logic [5:0]  vcount_shadow;
  logic [31:0] cut_masks_due[$];
  int          mismatches;
  int          cycle_count;
  int          words_sent;
  int          masks_seen;
  int          send_gap_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("articulation_point_finder_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      masks_seen++;
      if (cut_masks_due.size() == 0) begin
        $error("unexpected word: cut_mask actual %h", out_cut_mask);
        mismatches++;
      end else begin
        logic [31:0] want;
        want = cut_masks_due.pop_front();
        if (want !== out_cut_mask) begin
          $error("cut_mask expected %h actual %h", want, out_cut_mask);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [31:0] find_cut_vertices();
    int n;
    logic [31:0] live;
    logic [31:0] seen;
    logic [31:0] cut;
    logic [31:0] row;
    int disc[MaxV];
    int lowv[MaxV];
    int par[MaxV];
    int stk[MaxV];
    int pos[MaxV];
    int clock_n;
    int kids;
    int depth;
    int u;
    int p;
    int w;
    int pp;
    bit pushed;
    n = (vcount_shadow > MaxV) ? MaxV : int'(vcount_shadow);
    live = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    seen = '0;
    cut = '0;
    clock_n = 0;
    for (int r = 0; r < n; r++) begin
      if (seen[r]) continue;
      kids = 0;
      seen[r] = 1'b1;
      clock_n++;
      disc[r] = clock_n;
      lowv[r] = clock_n;
      par[r] = r;
      stk[0] = r;
      pos[0] = 0;
      depth = 1;
      while (depth > 0) begin
        u = stk[depth-1];
        p = pos[depth-1];
        row = graph_rows[u] & live;
        pushed = 0;
        while (p < n) begin
          w = p;
          p++;
          if (!row[w]) continue;
          if (!seen[w]) begin
            if (depth == 1) kids++;
            pos[depth-1] = p;
            seen[w] = 1'b1;
            clock_n++;
            disc[w] = clock_n;
            lowv[w] = clock_n;
            par[w] = u;
            stk[depth] = w;
            pos[depth] = 0;
            depth++;
            pushed = 1;
            break;
          end else if (w != par[u]) begin
            if (disc[w] < lowv[u]) lowv[u] = disc[w];
          end
        end
        if (pushed) continue;
        pos[depth-1] = p;
        depth--;
        if (depth > 0) begin
          pp = par[u];
          if (lowv[u] < lowv[pp]) lowv[pp] = lowv[u];
          if (depth > 1 && lowv[u] >= disc[pp]) cut[pp] = 1'b1;
        end
      end
      if (kids >= 2) cut[r] = 1'b1;
    end
    return cut;
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [4:0] a, input logic [4:0] b);
    int n;
    if ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = (vcount_shadow > MaxV) ? MaxV : int'(vcount_shadow);
    case (f)
      FUNC_ADD: begin
        if (a < n && b < n) begin
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
        end
      end
      FUNC_ANALYZE: cut_masks_due = {cut_masks_due, find_cut_vertices()};
      FUNC_CLEAR: for (int i = 0; i < MaxV; i++) graph_rows[i] = '0;
      default: ;
    endcase
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (cut_masks_due.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic set_vertex_count(input logic [5:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= {26'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    vcount_shadow = v;
  endtask

  task automatic test_directed();
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    send_word(FUNC_ADD, 5'd0, 5'd1);
    send_word(FUNC_ADD, 5'd1, 5'd2);
    send_word(FUNC_ADD, 5'd2, 5'd31);
    send_word(FUNC_ADD, 5'd31, 5'd30);
    send_word(FUNC_ADD, 5'd5, 5'd5);
    send_word(FUNC_ADD, 5'd0, 5'd1);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    send_word(FUNC_ADD, 5'd30, 5'd0);
    send_word(FUNC_RSVD, 5'd7, 5'd8);
    send_word(FUNC_ANALYZE, 5'd31, 5'd31);
    send_word(FUNC_ADD, 5'd1, 5'd10);
    send_word(FUNC_ADD, 5'd1, 5'd11);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    set_vertex_count(6'd8);
    send_word(FUNC_ADD, 5'd3, 5'd20);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    set_vertex_count(6'd1);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    set_vertex_count(6'd0);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    set_vertex_count(6'd63);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
    send_word(FUNC_CLEAR, 5'd31, 5'd31);
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
  endtask

  task automatic test_random_graphs(input int words, input logic [5:0] vc);
    int n;
    int k;
    int i;
    set_vertex_count(vc);
    n = (vc == 0) ? 1 : ((vc > 32) ? 32 : int'(vc));
    i = 0;
    while (i < words) begin
      k = $urandom_range(99);
      if (k < 4) send_word(FUNC_CLEAR, 5'($urandom), 5'($urandom));
      else if (k < 14) send_word(FUNC_ANALYZE, 5'($urandom), 5'($urandom));
      else if (k < 17) send_word(FUNC_RSVD, 5'($urandom), 5'($urandom));
      else if (k < 24) send_word(FUNC_ADD, 5'($urandom), 5'($urandom));
      else send_word(FUNC_ADD, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)));
      i++;
    end
    send_word(FUNC_ANALYZE, 5'd0, 5'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_ADD;
    in_node_a = '0;
    in_node_b = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    words_sent = 0;
    masks_seen = 0;
    send_gap_pct = 14;
    vcount_shadow = VCOUNT_RESET;
    for (int i = 0; i < MaxV; i++) graph_rows[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_graphs(60, 6'd32);
    test_random_graphs(60, 6'd12);
    test_random_graphs(60, 6'd5);
    send_gap_pct = 86;
    test_random_graphs(60, 6'd2);
    test_random_graphs(60, 6'd9);
    test_random_graphs(60, 6'd32);
    send_gap_pct = 0;
    test_random_graphs(60, 6'd16);
    test_random_graphs(60, 6'd7);
    test_random_graphs(60, 6'd32);
    drain();
    $display("covered %0d words and %0d cut masks over vertex counts 0 to 63",
             words_sent, masks_seen);
    if (mismatches == 0 && cut_masks_due.size() == 0) begin
      $display("articulation_point_finder_tb: done, clean");
    end else begin
      $display("articulation_point_finder_tb: done, errors");
    end
    $finish;
  end
endmodule

### articulation_point_finder.f
hw/rtl/apf_pkg.sv
hw/rtl/apf_ctrl.sv
hw/rtl/apf_dp.sv
hw/rtl/articulation_point_finder.sv
hw/rtl/apf_checker.sv
tb/sv/articulation_point_finder_tb.sv
